// ===== design/swfb_pkg.sv =====
// Shared types, widths and helpers for the sliding window feature basis block.
// No dependencies; imported by swfb_isqrt and sliding_window_feature_basis.
package swfb_pkg;

    // Payload widths
    localparam int SAMPLE_W    = 32;   // signed Q16.16 input sample
    localparam int BASE_W      = 33;   // signed base value (attr or point length)
    localparam int FEAT_W      = 33;   // signed feature value
    localparam int MAG_W       = 33;   // unsigned magnitude fed to the squarer
    localparam int PROD_W      = 2 * MAG_W;
    localparam int ACC_W       = 68;   // sum of up to three squares
    localparam int RAD_W       = 64;   // root unit radicand
    localparam int ROOT_W      = RAD_W / 2;
    localparam int IN_TDATA_W  = 4 * SAMPLE_W;
    localparam int OUT_TDATA_W = ((FEAT_W + 7) / 8) * 8;

    // Config register indexes and values
    localparam logic       REG_BASIS_MODE   = 1'b0;
    localparam logic       REG_USE_GEOMETRY = 1'b1;
    localparam logic [1:0] MODE_MAGNITUDE   = 2'd0;
    localparam logic [1:0] MODE_JUMP        = 2'd1;

    // Term loop: three squared terms per pass
    localparam logic [1:0] TERM_LAST = 2'd2;

    // Saturation bound of the feature
    localparam logic [FEAT_W-1:0] FEAT_MAX = {1'b0, {(FEAT_W-1){1'b1}}};

    // Root unit: one result bit per cycle
    localparam int                 SQRT_CNT_W = $clog2(ROOT_W);
    localparam logic [SQRT_CNT_W-1:0] SQRT_LAST = SQRT_CNT_W'(ROOT_W - 1);
    localparam logic [RAD_W-1:0]   SQRT_BIT0  = {2'b01, {(RAD_W-2){1'b0}}};

    // Divide by nine, one nibble per cycle over the accumulator
    localparam int                 DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(ACC_W / 4 - 1);
    localparam logic [7:0]         DIV_BY    = 8'd9;
    localparam logic [13:0]        RECIP9    = 14'd57;  // 57 / 2^9 ~ 1/9, exact below 144
    localparam int                 RECIP_SH  = 9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM_SEL,
        ST_TERM_MUL,
        ST_TERM_ACC,
        ST_SQRT_GO,
        ST_ROOT_WAIT,
        ST_DISPATCH,
        ST_FEAT_END,
        ST_DIV,
        ST_EMIT
    } swfb_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_sts_t;

    typedef struct packed {
        logic [3:0] quo;
        logic [3:0] rem;
    } div_digit_t;

    // One quotient digit of a division by nine; cur is below 144
    function automatic div_digit_t div9_digit(input logic [7:0] cur);
        logic [13:0] scaled;
        logic [7:0]  back;
        div_digit_t  d;
        scaled = 14'(cur) * RECIP9;
        d.quo  = scaled[RECIP_SH+3:RECIP_SH];
        back   = cur - 8'(d.quo) * DIV_BY;
        d.rem  = back[3:0];
        return d;
    endfunction

endpackage

// ===== design/sliding_window_feature_basis.sv =====
// Three-sample window feature (magnitude, neighbour jump, local std deviation).
// Depends on swfb_pkg and swfb_isqrt.
// The base is the attribute value or, in geometry mode, the point length from the root unit;
// each feature then comes from magnitude/jump directly, or for std from the shared 32-step
// root unit, after the 17-step divide by nine when three samples are present.
// Throughput: one request at a time; ready only in idle. Reset clears window and config.
module sliding_window_feature_basis (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [swfb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // attr_value, coord_x, coord_y, coord_z
    input  logic                                 s_axis_tlast,  // is_final
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [swfb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // feature, zero pad
    output logic                                 m_axis_tlast,  // final_flag
    // config write port
    input  logic                                 cfg_we,
    input  logic                                 cfg_addr,
    input  logic [1:0]                           cfg_wdata
);
    import swfb_pkg::*;

    // Config
    logic [1:0] mode_reg;
    logic       geom_reg;

    // Sequencer
    swfb_state_t state_reg, state_next;
    logic [1:0]  k_reg, k_next;
    logic        feat_phase_reg, feat_phase_next;
    logic        second_reg, second_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;

    // Window state
    logic signed [BASE_W-1:0] older_reg, older_next;
    logic signed [BASE_W-1:0] pending_reg, pending_next;
    logic [1:0]               seen_reg, seen_next;

    // Request payload
    logic signed [SAMPLE_W-1:0] cx_reg, cx_next;
    logic signed [SAMPLE_W-1:0] cy_reg, cy_next;
    logic signed [SAMPLE_W-1:0] cz_reg, cz_next;
    logic                       fin_reg, fin_next;

    // Datapath
    logic signed [BASE_W-1:0] cur_reg, cur_next;
    logic signed [BASE_W-1:0] fc_reg, fc_next;
    logic signed [BASE_W-1:0] fl_reg, fl_next;
    logic signed [BASE_W-1:0] fr_reg, fr_next;
    logic                     hl_reg, hl_next;
    logic                     hr_reg, hr_next;
    logic [MAG_W-1:0]         opnd_reg, opnd_next;
    logic [MAG_W-1:0]         jmax_reg, jmax_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [3:0]               drem_reg, drem_next;
    logic signed [FEAT_W-1:0] feat_reg, feat_next;

    // Output register
    logic                     ovalid_reg, ovalid_next;
    logic [FEAT_W-1:0]        ofeat_reg, ofeat_next;
    logic                     olast_reg, olast_next;

    // Term select
    logic signed [BASE_W-1:0] coord_sel;
    logic [MAG_W-1:0]         coord_abs;
    logic signed [BASE_W-1:0] pair_x, pair_y;
    logic signed [BASE_W:0]   pair_d;
    logic [BASE_W:0]          pair_abs;
    logic                     pair_ok;
    logic [MAG_W-1:0]         term_mag;

    // Root unit
    logic                 sqrt_start;
    logic [ROOT_W-1:0]    sqrt_root;
    sqrt_sts_t            sqrt_sts;
    div_digit_t           digit;

    logic in_accept;
    logic slot_free;
    logic out_load;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign slot_free = !ovalid_reg || m_axis_tready;
    assign out_load  = (state_reg == ST_EMIT) && slot_free;
    assign digit     = div9_digit({drem_reg, acc_reg[ACC_W-1:ACC_W-4]});

    swfb_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg[RAD_W-1:0]),
        .root     (sqrt_root),
        .sts      (sqrt_sts)
    );

    // Coordinate magnitude for the point length pass
    always_comb
    begin
        unique case (k_reg)
            2'd0:    coord_sel = BASE_W'(cx_reg);
            2'd1:    coord_sel = BASE_W'(cy_reg);
            default: coord_sel = BASE_W'(cz_reg);
        endcase
        coord_abs = coord_sel[BASE_W-1] ? MAG_W'(-coord_sel) : MAG_W'(coord_sel);
    end

    // Neighbour pair for the feature pass: (c,l), (c,r), (l,r)
    always_comb
    begin
        unique case (k_reg)
            2'd0:
            begin
                pair_x  = fc_reg;
                pair_y  = fl_reg;
                pair_ok = hl_reg;
            end
            2'd1:
            begin
                pair_x  = fc_reg;
                pair_y  = fr_reg;
                pair_ok = hr_reg;
            end
            default:
            begin
                pair_x  = fl_reg;
                pair_y  = fr_reg;
                pair_ok = hl_reg && hr_reg;
            end
        endcase
        pair_d   = (BASE_W+1)'(pair_x) - (BASE_W+1)'(pair_y);
        pair_abs = pair_d[BASE_W] ? (BASE_W+1)'(-pair_d) : (BASE_W+1)'(pair_d);
        if (!feat_phase_reg)
            term_mag = coord_abs;
        else if (pair_ok)
            term_mag = pair_abs[MAG_W-1:0];
        else
            term_mag = '0;
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        feat_phase_next = feat_phase_reg;
        second_next     = second_reg;
        dcnt_next       = dcnt_reg;
        older_next      = older_reg;
        pending_next    = pending_reg;
        seen_next       = seen_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        fin_next        = fin_reg;
        cur_next        = cur_reg;
        fc_next         = fc_reg;
        fl_next         = fl_reg;
        fr_next         = fr_reg;
        hl_next         = hl_reg;
        hr_next         = hr_reg;
        opnd_next       = opnd_reg;
        jmax_next       = jmax_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        drem_next       = drem_reg;
        feat_next       = feat_reg;
        ovalid_next     = ovalid_reg && !m_axis_tready;
        ofeat_next      = ofeat_reg;
        olast_next      = olast_reg;
        sqrt_start      = 1'b0;
        s_axis_tready   = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cx_next   = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
                    cy_next   = s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
                    cz_next   = s_axis_tdata[4*SAMPLE_W-1:3*SAMPLE_W];
                    fin_next  = s_axis_tlast;
                    if (geom_reg)
                    begin
                        feat_phase_next = 1'b0;
                        k_next          = '0;
                        acc_next        = '0;
                        state_next      = ST_TERM_SEL;
                    end
                    else
                    begin
                        cur_next   = BASE_W'($signed(s_axis_tdata[SAMPLE_W-1:0]));
                        state_next = ST_DISPATCH;
                    end
                end
            end

            // Shared squarer loop: select, square, accumulate
            ST_TERM_SEL:
            begin
                opnd_next = term_mag;
                // jump only looks at the centre sample's own neighbours
                if (feat_phase_reg && k_reg != TERM_LAST && term_mag > jmax_reg)
                    jmax_next = term_mag;
                state_next = ST_TERM_MUL;
            end

            ST_TERM_MUL:
            begin
                prod_next  = opnd_reg * opnd_reg;
                state_next = ST_TERM_ACC;
            end

            ST_TERM_ACC:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                if (k_reg == TERM_LAST)
                    state_next = feat_phase_reg ? ST_FEAT_END : ST_SQRT_GO;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_TERM_SEL;
                end
            end

            ST_SQRT_GO:
            begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT_WAIT;
            end

            ST_ROOT_WAIT:
            begin
                if (sqrt_sts.done)
                begin
                    if (feat_phase_reg)
                    begin
                        feat_next  = {1'b0, sqrt_root};
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cur_next   = {1'b0, sqrt_root};
                        state_next = ST_DISPATCH;
                    end
                end
            end

            // Base value ready: decide what the window owes
            ST_DISPATCH:
            begin
                if (seen_reg == 2'd0)
                begin
                    if (fin_reg)
                    begin
                        feat_next   = cur_reg;
                        second_next = 1'b1;
                        state_next  = ST_EMIT;
                    end
                    else
                    begin
                        older_next   = pending_reg;
                        pending_next = cur_reg;
                        seen_next    = 2'd1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    fc_next         = pending_reg;
                    fl_next         = older_reg;
                    fr_next         = cur_reg;
                    hl_next         = seen_reg[1];
                    hr_next         = 1'b1;
                    second_next     = 1'b0;
                    feat_phase_next = 1'b1;
                    k_next          = '0;
                    acc_next        = '0;
                    jmax_next       = '0;
                    state_next      = ST_TERM_SEL;
                end
            end

            ST_FEAT_END:
            begin
                unique case (mode_reg)
                    MODE_MAGNITUDE:
                    begin
                        feat_next  = fc_reg;
                        state_next = ST_EMIT;
                    end
                    MODE_JUMP:
                    begin
                        feat_next  = jmax_reg[MAG_W-1] ? FEAT_MAX : jmax_reg;
                        state_next = ST_EMIT;
                    end
                    default:
                    begin
                        if (hl_reg && hr_reg)
                        begin
                            dcnt_next  = '0;
                            drem_next  = '0;
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            acc_next   = acc_reg >> 2;
                            state_next = ST_SQRT_GO;
                        end
                    end
                endcase
            end

            // Three-sample window: sum of squares / 9, nibble by nibble
            ST_DIV:
            begin
                acc_next  = {acc_reg[ACC_W-5:0], digit.quo};
                drem_next = digit.rem;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_LAST)
                    state_next = ST_SQRT_GO;
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ofeat_next  = feat_reg;
                    olast_next  = second_reg;
                    if (fin_reg && !second_reg)
                    begin
                        // Flush: feature of the last sample, left neighbour only
                        fc_next         = cur_reg;
                        fl_next         = pending_reg;
                        fr_next         = cur_reg;
                        hl_next         = 1'b1;
                        hr_next         = 1'b0;
                        second_next     = 1'b1;
                        feat_phase_next = 1'b1;
                        k_next          = '0;
                        acc_next        = '0;
                        jmax_next       = '0;
                        state_next      = ST_TERM_SEL;
                    end
                    else
                    begin
                        if (fin_reg)
                        begin
                            older_next   = '0;
                            pending_next = '0;
                            seen_next    = 2'd0;
                        end
                        else
                        begin
                            older_next   = pending_reg;
                            pending_next = cur_reg;
                            seen_next    = seen_reg[1] ? 2'd2 : seen_reg + 2'd1;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MAGNITUDE;
            geom_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_BASIS_MODE)
                mode_reg <= cfg_wdata;
            else if (cfg_addr == REG_USE_GEOMETRY)
                geom_reg <= cfg_wdata[0];
        end
    end

    // Control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            feat_phase_reg <= 1'b0;
            second_reg     <= 1'b0;
            dcnt_reg       <= '0;
            older_reg      <= '0;
            pending_reg    <= '0;
            seen_reg       <= 2'd0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            feat_phase_reg <= feat_phase_next;
            second_reg     <= second_next;
            dcnt_reg       <= dcnt_next;
            older_reg      <= older_next;
            pending_reg    <= pending_next;
            seen_reg       <= seen_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        fin_reg   <= fin_next;
        cur_reg   <= cur_next;
        fc_reg    <= fc_next;
        fl_reg    <= fl_next;
        fr_reg    <= fr_next;
        hl_reg    <= hl_next;
        hr_reg    <= hr_next;
        opnd_reg  <= opnd_next;
        jmax_reg  <= jmax_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        drem_reg  <= drem_next;
        feat_reg  <= feat_next;
        ofeat_reg <= ofeat_next;
        olast_reg <= olast_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-FEAT_W){1'b0}}, ofeat_reg};
    assign m_axis_tlast  = olast_reg;

`ifndef SYNTH
    // Root results arrive only while the sequencer waits for them
    a_root_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_sts.done |-> state_reg == ST_ROOT_WAIT)
        else $error("root result outside wait state");

    // A root is only started on an idle root unit
    a_root_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_sts.busy)
        else $error("root started while busy");

    // Window fill count saturates at two
    a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg != 2'd3)
        else $error("window fill count out of range");

    // A flagged feature only goes out for a final sample
    a_flag_needs_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && second_reg) |-> fin_reg)
        else $error("final flag without final sample");

    // After a final sample the window is empty
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && second_reg) |=> seen_reg == 2'd0)
        else $error("window not cleared after final sample");
`endif

endmodule

// ===== design/swfb_isqrt.sv =====
// Iterative integer square root, one result bit per cycle (digit by digit).
// Depends on swfb_pkg for widths and the status struct.
module swfb_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [swfb_pkg::RAD_W-1:0]  radicand,
    output logic [swfb_pkg::ROOT_W-1:0] root,
    output swfb_pkg::sqrt_sts_t         sts
);
    import swfb_pkg::*;

    logic [RAD_W-1:0]      rem_reg, rem_next;
    logic [RAD_W-1:0]      res_reg, res_next;
    logic [RAD_W-1:0]      bit_reg, bit_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [RAD_W:0]        trial;
    logic                  take;

    // Trial subtract of res + bit from the remainder
    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};
    assign take  = ({1'b0, rem_reg} >= trial);

    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = SQRT_BIT0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                rem_next = rem_reg - trial[RAD_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SQRT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign root     = res_reg[ROOT_W-1:0];
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule
